// File: hdl/gnd_pkg.sv
package gnd_pkg;

    // Number of denomination slots that take part in a run (1 to 8).
    localparam int SLOTS     = 8;
    // Denomination registers that the configuration port holds.
    localparam int REG_COUNT = 8;

    localparam int DENOM_W   = 16;
    localparam int AMOUNT_W  = 32;
    localparam int CFG_IDX_W = 8;

    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PHASE_W   = $clog2(SLOTS + 1);
    localparam int DIV_CNT_W = $clog2(AMOUNT_W + 1);

    typedef logic [DENOM_W-1:0]  denom_t;
    typedef logic [AMOUNT_W-1:0] amount_t;

    // Sorter controls: load a fresh copy of the registers, or drop the head.
    typedef struct packed {
        logic load;
        logic shift;
    } sort_ctl_t;

    // Divider controls.
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SORT,
        ST_SLOT,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

// File: hdl/gnd_sorter.sv
// Odd-even transposition sort, one phase per cycle, largest value first.
// Once sorted, the row is shifted towards the head one slot at a time.
module gnd_sorter
    import gnd_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  sort_ctl_t                 ctl,
    input  denom_t [REG_COUNT-1:0]    denoms,
    output denom_t                    head,
    output logic                      done
);

    denom_t [SLOTS-1:0]   arr_reg;
    denom_t [SLOTS-1:0]   arr_next;
    denom_t [SLOTS-1:0]   swap_net;
    logic [PHASE_W-1:0]   phase_reg;
    logic [PHASE_W-1:0]   phase_next;

    assign done = (phase_reg == PHASE_W'(SLOTS));
    assign head = arr_reg[0];

    // Pairs in one phase are disjoint, so all swaps happen side by side.
    always_comb begin
        swap_net = arr_reg;
        for (int i = 0; i < SLOTS - 1; i++) begin
            if ((1'(i) == phase_reg[0]) && (arr_reg[i+1] > arr_reg[i])) begin
                swap_net[i]   = arr_reg[i+1];
                swap_net[i+1] = arr_reg[i];
            end
        end
    end

    always_comb begin
        arr_next   = arr_reg;
        phase_next = phase_reg;
        if (ctl.load) begin
            arr_next   = denoms[SLOTS-1:0];
            phase_next = '0;
        end else if (!done) begin
            arr_next   = swap_net;
            phase_next = phase_reg + PHASE_W'(1);
        end else if (ctl.shift) begin
            for (int i = 0; i < SLOTS - 1; i++) begin
                arr_next[i] = arr_reg[i+1];
            end
            arr_next[SLOTS-1] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_W'(SLOTS);
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        arr_reg <= arr_next;
    end

endmodule

// File: hdl/gnd_divider.sv
// Restoring divider, one quotient bit per cycle. The dividend register
// doubles as the quotient register: dividend bits leave at the top while
// quotient bits enter at the bottom.
module gnd_divider
    import gnd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  div_ctl_t  ctl,
    input  amount_t   dividend,
    input  denom_t    divisor,
    output amount_t   quotient,
    output denom_t    remainder,
    output logic      busy
);

    amount_t                quo_reg;
    amount_t                quo_next;
    denom_t                 rem_reg;
    denom_t                 rem_next;
    denom_t                 dsr_reg;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_CNT_W-1:0]   cnt_next;
    logic                   busy_reg;
    logic                   busy_next;

    logic [DENOM_W:0]       trial;
    logic [DENOM_W:0]       diff;
    logic                   fits;

    assign trial = {rem_reg, quo_reg[AMOUNT_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (ctl.start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(AMOUNT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[AMOUNT_W-2:0], fits};
            rem_next  = fits ? diff[DENOM_W-1:0] : trial[DENOM_W-1:0];
            cnt_next  = cnt_reg - DIV_CNT_W'(1);
            busy_next = (cnt_reg != DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (ctl.start) begin
            dsr_reg <= divisor;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign busy      = busy_reg;

endmodule

// File: hdl/greedy_note_dispenser.sv
// A run sorts the denominations, then works each slot in turn, with a division
// only where the slot is used and an amount is left to pay out.
// One withdrawal at a time; the next beat is taken once the last result of
// the run has been loaded into the output register.
// Reset (aresetn, synchronous, active low) clears all denominations to zero,
// empties the output register and returns the controller to idle.
module greedy_note_dispenser
    import gnd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [AMOUNT_W-1:0]   s_amount,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DENOM_W-1:0]    m_note_value,
    output logic [AMOUNT_W-1:0]   m_note_count,
    output logic [AMOUNT_W-1:0]   m_amount_left,
    output logic                  m_last,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DENOM_W-1:0]    cfg_data
);

    // Denomination registers. Writes are always taken; an index beyond the
    // register list is simply dropped.
    denom_t [REG_COUNT-1:0] denom_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            denom_reg <= '0;
        end else if (cfg_valid && cfg_ready &&
                     (cfg_index < CFG_IDX_W'(REG_COUNT))) begin
            denom_reg[cfg_index[$clog2(REG_COUNT)-1:0]] <= cfg_data;
        end
    end

    // Controller state and run registers.
    state_t               state_reg;
    state_t               state_next;
    amount_t              left_reg;
    amount_t              count_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 last_slot;

    // Output register, which lets a result wait while the next one is worked.
    logic                 m_valid_reg;
    denom_t               m_note_value_reg;
    amount_t              m_note_count_reg;
    amount_t              m_amount_left_reg;
    logic                 m_last_reg;
    logic                 out_free;

    sort_ctl_t            sort_ctl;
    div_ctl_t             div_ctl;
    denom_t               head;
    logic                 sort_done;
    amount_t              quotient;
    denom_t               remainder;
    logic                 div_busy;
    logic                 skip_div;

    assign last_slot = (slot_reg == SLOT_W'(SLOTS - 1));
    assign out_free  = !m_valid_reg || m_ready;
    // An unused slot, or nothing left to pay out, gives a count of zero and
    // leaves the amount as it stands, with no division.
    assign skip_div  = (head == '0) || (left_reg == '0);

    gnd_sorter u_sorter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (sort_ctl),
        .denoms  (denom_reg),
        .head    (head),
        .done    (sort_done)
    );

    gnd_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (div_ctl),
        .dividend  (left_reg),
        .divisor   (head),
        .quotient  (quotient),
        .remainder (remainder),
        .busy      (div_busy)
    );

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT: begin
                if (sort_done) begin
                    state_next = ST_SLOT;
                end
            end
            ST_SLOT: begin
                state_next = skip_div ? ST_EMIT : ST_DIV;
            end
            ST_DIV: begin
                if (!div_busy) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = last_slot ? ST_IDLE : ST_SLOT;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb begin
        s_ready        = 1'b0;
        sort_ctl.load  = 1'b0;
        sort_ctl.shift = 1'b0;
        div_ctl.start  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                sort_ctl.load = s_valid;
            end
            ST_SORT: begin
            end
            ST_SLOT: begin
                div_ctl.start = !skip_div;
            end
            ST_DIV: begin
            end
            ST_EMIT: begin
                sort_ctl.shift = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE) begin
                slot_reg <= '0;
            end else if ((state_reg == ST_EMIT) && out_free) begin
                slot_reg <= slot_reg + SLOT_W'(1);
            end
            if ((state_reg == ST_EMIT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Run datapath: the amount still to pay and the count of this slot.
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_IDLE) && s_valid) begin
            left_reg <= s_amount;
        end else if ((state_reg == ST_DIV) && !div_busy) begin
            left_reg <= AMOUNT_W'(remainder);
        end
        if (state_reg == ST_SLOT) begin
            count_reg <= '0;
        end else if ((state_reg == ST_DIV) && !div_busy) begin
            count_reg <= quotient;
        end
        if ((state_reg == ST_EMIT) && out_free) begin
            m_note_value_reg  <= head;
            m_note_count_reg  <= count_reg;
            m_amount_left_reg <= left_reg;
            m_last_reg        <= last_slot;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_note_value  = m_note_value_reg;
    assign m_note_count  = m_note_count_reg;
    assign m_amount_left = m_amount_left_reg;
    assign m_last        = m_last_reg;

endmodule

// File: tb/greedy_note_dispenser_test.sv
module greedy_note_dispenser_test;
    import gnd_pkg::*;

    // Timing of the bench, with the settle pause before a register write and the
    // tail at the end.
    localparam int CLK_PERIOD      = 10;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 300;
    localparam int HOLD_CYCLES     = 1500;
    localparam int LIMIT_CYCLES    = 1000000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 38;

    typedef struct packed {
        denom_t  note_value;
        amount_t note_count;
        amount_t amount_left;
        logic    last;
    } dispense_t;

    // Rows of the directed part: either a register write or a withdrawal.
    // Where the outcome can be read off at a glance, the row also carries the
    // head result and the remainder after the final slot.
    typedef enum logic {
        ROW_WRITE,
        ROW_AMOUNT
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] index;
        amount_t              value;
        logic                 typed;
        denom_t               top_value;
        amount_t              top_count;
        amount_t              rest;
    } plan_row_t;

    localparam int PLAN_ROWS = 23;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [AMOUNT_W-1:0]  s_amount;
    logic                 m_valid;
    logic                 m_ready;
    logic [DENOM_W-1:0]   m_note_value;
    logic [AMOUNT_W-1:0]  m_note_count;
    logic [AMOUNT_W-1:0]  m_amount_left;
    logic                 m_last;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DENOM_W-1:0]   cfg_data;

    // Shadow copy of the denomination registers, updated as writes land.
    denom_t    denom_reg [REG_COUNT];
    // Results still owed by the block, oldest at the front.
    dispense_t dispense_q [$];
    int        mismatches = 0;
    // Set by the stimulus to ask the receiver for one long hold-off.
    logic      hold_request;
    // Set for the closing phases, where neither side idles.
    logic      quiet;

    plan_row_t plan [PLAN_ROWS] = '{
        // Straight after reset every slot is unused, so nothing is dispensed.
        '{ROW_AMOUNT, 8'd0, 32'd0,          1'b1, 16'd0, 32'd0, 32'd0},
        '{ROW_AMOUNT, 8'd0, 32'hFFFF_FFFF,  1'b1, 16'd0, 32'd0, 32'hFFFF_FFFF},
        // Deliberately unsorted, with two unused slots in the middle.
        '{ROW_WRITE,  8'd0, 32'd1,          1'b0, 16'd0, 32'd0, 32'd0},
        '{ROW_WRITE,  8'd1, 32'd500,        1'b0, 16'd0, 32'd0, 32'd0},
        '{ROW_WRITE,  8'd2, 32'd0,          1'b0, 16'd0, 32'd0, 32'd0},
        '{ROW_WRITE,  8'd3, 32'd20000,      1'b0, 16'd0, 32'd0, 32'd0},
        '{ROW_WRITE,  8'd4, 32'd0,          1'b0, 16'd0, 32'd0, 32'd0},
        '{ROW_WRITE,  8'd5, 32'd50000,      1'b0, 16'd0, 32'd0, 32'd0},
        '{ROW_WRITE,  8'd6, 32'd2000,       1'b0, 16'd0, 32'd0, 32'd0},
        '{ROW_WRITE,  8'd7, 32'd65535,      1'b0, 16'd0, 32'd0, 32'd0},
        // The largest note clears the full-scale amount exactly.
        '{ROW_AMOUNT, 8'd0, 32'hFFFF_FFFF,  1'b1, 16'd65535, 32'd65537, 32'd0},
        '{ROW_AMOUNT, 8'd0, 32'hFFFF_FFFE,  1'b1, 16'd65535, 32'd65536, 32'd0},
        '{ROW_AMOUNT, 8'd0, 32'd0,          1'b1, 16'd65535, 32'd0, 32'd0},
        '{ROW_AMOUNT, 8'd0, 32'd1,          1'b1, 16'd65535, 32'd0, 32'd0},
        '{ROW_AMOUNT, 8'd0, 32'd123456,     1'b0, 16'd0, 32'd0, 32'd0},
        // Writes beyond the last register must leave every slot alone.
        '{ROW_WRITE,  8'd8, 32'd3,          1'b0, 16'd0, 32'd0, 32'd0},
        '{ROW_WRITE,  8'd255, 32'h8000,     1'b0, 16'd0, 32'd0, 32'd0},
        '{ROW_AMOUNT, 8'd0, 32'd115538,     1'b0, 16'd0, 32'd0, 32'd0},
        '{ROW_WRITE,  8'd7, 32'd0,          1'b0, 16'd0, 32'd0, 32'd0},
        '{ROW_AMOUNT, 8'd0, 32'd100000,     1'b1, 16'd50000, 32'd2, 32'd0},
        // Two equal notes: the first takes the whole share.
        '{ROW_WRITE,  8'd1, 32'd50000,      1'b0, 16'd0, 32'd0, 32'd0},
        '{ROW_AMOUNT, 8'd0, 32'd150000,     1'b1, 16'd50000, 32'd3, 32'd0},
        '{ROW_AMOUNT, 8'd0, 32'd99999,      1'b0, 16'd0, 32'd0, 32'd0}
    };

    greedy_note_dispenser DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_amount      (s_amount),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_note_value  (m_note_value),
        .m_note_count  (m_note_count),
        .m_amount_left (m_amount_left),
        .m_last        (m_last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        #(CLK_PERIOD / 2) aclk = 1'b1;
        #(CLK_PERIOD / 2) aclk = 1'b0;
    end

    // One line per mismatch, and every mismatch is counted.
    task automatic report_mismatch(input string what, input logic [AMOUNT_W-1:0] got,
                                   input logic [AMOUNT_W-1:0] want);
        $display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Greedy split of one withdrawal under the current denominations. The
    // first SLOTS registers are bubble-sorted largest first, so unused slots
    // (zero) sink to the end. Each slot takes as many notes as fit into what
    // is left; an unused slot, or nothing left, gives a count of zero. The
    // full set of results is queued, and the head result and the final
    // remainder are handed back for the directed rows.
    function automatic void predict_dispense(input amount_t amount, output dispense_t head,
                                             output amount_t rest);
        denom_t    order [SLOTS];
        denom_t    swap;
        amount_t   left;
        amount_t   count;
        dispense_t beat;
        left = amount;
        for (int i = 0; i < SLOTS; i++) begin
            order[i] = denom_reg[i];
        end
        for (int i = 0; i + 1 < SLOTS; i++) begin
            for (int j = SLOTS - 1; j > i; j--) begin
                if (order[j] > order[j-1]) begin
                    swap       = order[j];
                    order[j]   = order[j-1];
                    order[j-1] = swap;
                end
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            count = '0;
            if (order[i] != '0 && left != '0) begin
                count = left / amount_t'(order[i]);
                left  = left - count * amount_t'(order[i]);
            end
            beat.note_value  = order[i];
            beat.note_count  = count;
            beat.amount_left = left;
            beat.last        = (i == SLOTS - 1);
            if (i == 0) begin
                head = beat;
            end
            dispense_q.push_back(beat);
        end
        rest = left;
    endfunction

    // Offers one withdrawal beat, sometimes after a burst of idle cycles,
    // and queues its expected results once the block has taken it. Called
    // and returns at a falling edge; valid is left high so that a following
    // beat can go out without a gap.
    task automatic offer_amount(input amount_t amount, output dispense_t head,
                                output amount_t rest);
        if (!quiet && $urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_amount <= amount;
        do @(posedge aclk); while (!s_ready);
        predict_dispense(amount, head, rest);
        @(negedge aclk);
    endtask

    // One register write beat. Indexes past the last register are offered
    // to the block too, but the shadow copy ignores them. The caller lowers
    // cfg_valid once a batch of writes is done.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input denom_t value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index < REG_COUNT) begin
            denom_reg[index] = value;
        end
        @(negedge aclk);
    endtask

    // Stops offering withdrawals and waits until every owed result has been
    // taken, then a short pause so that the block is surely back at rest.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (dispense_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Denominations for one random phase: the first phase sets every slot to
    // the largest note, another leaves every slot unused, another gives every
    // slot the same value, and the rest mix unused slots, ones, the largest
    // note, small notes and anything at all.
    function automatic denom_t pick_denomination(input int phase, input denom_t shared);
        case (phase)
            0: begin
                return 16'hFFFF;
            end
            3: begin
                return '0;
            end
            5: begin
                return shared;
            end
            default: begin
                case ($urandom_range(0, 4))
                    0: return '0;
                    1: return 16'd1;
                    2: return 16'hFFFF;
                    3: return denom_t'($urandom_range(2, 100));
                    default: return denom_t'($urandom_range(0, 65535));
                endcase
            end
        endcase
    endfunction

    // Withdrawals: full-range values, small ones, the two extremes, exact
    // multiples of a configured note, and values of random magnitude.
    function automatic amount_t pick_amount();
        case ($urandom_range(0, 5))
            0: return amount_t'($urandom);
            1: return amount_t'($urandom_range(0, 1000));
            2: return '0;
            3: return 32'hFFFF_FFFF;
            4: return amount_t'(denom_reg[$urandom_range(0, SLOTS - 1)]) *
                      amount_t'($urandom_range(0, 65535));
            default: return amount_t'($urandom) >> $urandom_range(0, 31);
        endcase
    endfunction

    // Receiver. Each pass picks a level for m_ready and holds it for a
    // stretch, so that at most one assignment falls in any time step. A
    // pending hold request gives the one long hold-off, during which the
    // block fills up and must stall its input.
    initial begin
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge aclk);
            end
        end
    end

    // Result checker: every beat taken is compared, field by field, with the
    // oldest result still owed.
    always @(posedge aclk) begin
        dispense_t want;
        if (aresetn && m_valid && m_ready) begin
            if (dispense_q.size() == 0) begin
                report_mismatch("result beat with nothing owed", AMOUNT_W'(m_note_value),
                                '0);
            end else begin
                want = dispense_q.pop_front();
                if (m_note_value !== want.note_value) begin
                    report_mismatch("note_value", AMOUNT_W'(m_note_value),
                                    AMOUNT_W'(want.note_value));
                end
                if (m_note_count !== want.note_count) begin
                    report_mismatch("note_count", m_note_count, want.note_count);
                end
                if (m_amount_left !== want.amount_left) begin
                    report_mismatch("amount_left", m_amount_left, want.amount_left);
                end
                if (m_last !== want.last) begin
                    report_mismatch("last", AMOUNT_W'(m_last), AMOUNT_W'(want.last));
                end
            end
        end
    end

    // Main stimulus: reset, the directed rows, then the random phases.
    initial begin
        dispense_t head;
        amount_t   rest;
        denom_t    shared;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_amount     = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        hold_request = 1'b0;
        quiet        = 1'b0;
        for (int i = 0; i < REG_COUNT; i++) begin
            denom_reg[i] = '0;
        end
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part. Writes only go in once the block has handed over
        // every owed result; a withdrawal row that follows a batch of writes
        // closes that batch.
        for (int k = 0; k < PLAN_ROWS; k++) begin
            if (plan[k].kind == ROW_WRITE) begin
                if (k == 0 || plan[k-1].kind != ROW_WRITE) begin
                    drain_results();
                end
                write_register(plan[k].index, plan[k].value[DENOM_W-1:0]);
            end else begin
                if (k > 0 && plan[k-1].kind == ROW_WRITE) begin
                    cfg_valid <= 1'b0;
                end
                offer_amount(plan[k].value, head, rest);
                if (plan[k].typed) begin
                    if (head.note_value !== plan[k].top_value) begin
                        report_mismatch("table head note_value", AMOUNT_W'(head.note_value),
                                        AMOUNT_W'(plan[k].top_value));
                    end
                    if (head.note_count !== plan[k].top_count) begin
                        report_mismatch("table head note_count", head.note_count,
                                        plan[k].top_count);
                    end
                    if (rest !== plan[k].rest) begin
                        report_mismatch("table final amount_left", rest, plan[k].rest);
                    end
                end
            end
        end

        // Random phases, each under fresh denominations and now and then a
        // stray write beyond the last register. The second phase asks for
        // the long hold-off early on; the last two run without idling.
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            shared = denom_t'($urandom_range(1, 65535));
            for (int r = 0; r < REG_COUNT; r++) begin
                write_register(CFG_IDX_W'(r), pick_denomination(p, shared));
            end
            if ($urandom_range(0, 2) == 0) begin
                write_register(CFG_IDX_W'($urandom_range(REG_COUNT, 255)),
                               denom_t'($urandom));
            end
            cfg_valid <= 1'b0;
            quiet = (p >= PHASES - 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 1 && n == 4) begin
                    hold_request = 1'b1;
                end
                offer_amount(pick_amount(), head, rest);
            end
        end

        // Let the last results out, then watch a while longer for any beat
        // the block should not send.
        drain_results();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatches == 0 && dispense_q.size() == 0) begin
            $display("greedy_note_dispenser: match");
        end else begin
            $display("greedy_note_dispenser: mismatch");
        end
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("greedy_note_dispenser: mismatch");
        $finish;
    end

endmodule
